>>> rtl/core/atpr_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle package
// Shared widths, constants, the arctangent table and the angle finishing
// function of the accelerometer tilt block.
// ----------------------------------------------------------------------------
`default_nettype none

package atpr_pkg;

   // Field widths of the sample and result beats.
   localparam int ACCEL_W = 16;
   localparam int PITCH_W = 15;
   localparam int ROLL_W  = 16;

   // Vector components: counts times 256 plus CORDIC growth.
   localparam int GUARD_BITS = 8;
   localparam int COMP_W     = 28;

   // Angle accumulator: degrees with 20 fraction bits.
   localparam int ACC_FRAC = 20;
   localparam int ACC_W    = 30;

   localparam int TABLE_LEN = 24;

   // Inverse CORDIC gain, round(0.6072529350 * 2^16).
   localparam int INV_GAIN_W = 16;
   localparam logic [INV_GAIN_W-1:0] INV_GAIN = 16'd39797;
   localparam int GAIN_SHIFT = 16;

   localparam logic signed [ACC_W-1:0] HALF_TURN = ACC_W'(180 * (1 << ACC_FRAC));

   localparam int PITCH_LIMIT_DEG = 90;
   localparam int ROLL_LIMIT_DEG  = 180;

   // round(atan(2^-i) in degrees * 2^20)
   function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
      logic signed [ACC_W-1:0] v;
      case (idx)
         0:  v = 30'sd47185920;
         1:  v = 30'sd27855475;
         2:  v = 30'sd14718068;
         3:  v = 30'sd7471121;
         4:  v = 30'sd3750058;
         5:  v = 30'sd1876857;
         6:  v = 30'sd938658;
         7:  v = 30'sd469357;
         8:  v = 30'sd234682;
         9:  v = 30'sd117342;
         10: v = 30'sd58671;
         11: v = 30'sd29335;
         12: v = 30'sd14668;
         13: v = 30'sd7334;
         14: v = 30'sd3667;
         15: v = 30'sd1833;
         16: v = 30'sd917;
         17: v = 30'sd458;
         18: v = 30'sd229;
         19: v = 30'sd115;
         20: v = 30'sd57;
         21: v = 30'sd29;
         22: v = 30'sd14;
         23: v = 30'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Round half up to frac fraction bits, clamp to +-lim_deg, then saturate
   // to a signed field of the given width.
   function automatic logic signed [ACC_W-1:0] finish_angle(
      input logic signed [ACC_W-1:0] acc,
      input int                      frac,
      input int                      lim_deg,
      input int                      width
   );
      logic signed [ACC_W:0] r;
      logic signed [ACC_W:0] lim;
      logic signed [ACC_W:0] wmax;
      logic signed [ACC_W:0] wmin;
      int s;
      s    = ACC_FRAC - frac;
      r    = $signed((ACC_W+1)'(acc)) + $signed((ACC_W+1)'(1) << (s - 1));
      r    = r >>> s;
      lim  = $signed((ACC_W+1)'(lim_deg) << frac);
      wmax = $signed(((ACC_W+1)'(1) << (width - 1)) - (ACC_W+1)'(1));
      wmin = -$signed((ACC_W+1)'(1) << (width - 1));
      if (r > lim) begin
         r = lim;
      end
      if (r < -lim) begin
         r = -lim;
      end
      if (r > wmax) begin
         r = wmax;
      end
      if (r < wmin) begin
         r = wmin;
      end
      return ACC_W'(r);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/atpr_if.sv
// ----------------------------------------------------------------------------
// Tilt angle channels
// Valid/ready channels for accelerometer sample beats and angle result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface atpr_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [atpr_pkg::ACCEL_W-1:0]     accel_x;
   logic signed [atpr_pkg::ACCEL_W-1:0]     accel_y;
   logic signed [atpr_pkg::ACCEL_W-1:0]     accel_z;

   modport source (output valid, output accel_x, output accel_y, output accel_z,
                   input ready);
   modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                   output ready);
endinterface

interface atpr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [atpr_pkg::PITCH_W-1:0]     pitch_angle;
   logic signed [atpr_pkg::ROLL_W-1:0]      roll_angle;

   modport source (output valid, output pitch_angle, output roll_angle, input ready);
   modport sink   (input valid, input pitch_angle, input roll_angle, output ready);
endinterface

`default_nettype wire

>>> rtl/core/atpr_cordic.sv
// ----------------------------------------------------------------------------
// Tilt angle CORDIC pass
// Unrolled vectoring CORDIC, one micro-rotation per register stage, with a
// sideband word carried alongside each beat.
// ----------------------------------------------------------------------------
`default_nettype none

module atpr_cordic #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 1
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire logic signed [atpr_pkg::COMP_W-1:0]    in_x,
   input  wire logic signed [atpr_pkg::COMP_W-1:0]    in_y,
   input  wire logic signed [atpr_pkg::ACC_W-1:0]     in_acc,
   input  wire logic        [SIDE_W-1:0]              in_side,
   output logic                                       out_valid,
   output logic signed [atpr_pkg::COMP_W-1:0]         out_x,
   output logic signed [atpr_pkg::ACC_W-1:0]          out_acc,
   output logic        [SIDE_W-1:0]                   out_side
);

   logic        [STEPS-1:0]               valid_ff;
   logic signed [atpr_pkg::COMP_W-1:0]    x_ff    [STEPS];
   logic signed [atpr_pkg::COMP_W-1:0]    y_ff    [STEPS];
   logic signed [atpr_pkg::ACC_W-1:0]     acc_ff  [STEPS];
   logic        [SIDE_W-1:0]              side_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic                               v_prev;
      logic signed [atpr_pkg::COMP_W-1:0] x_prev;
      logic signed [atpr_pkg::COMP_W-1:0] y_prev;
      logic signed [atpr_pkg::ACC_W-1:0]  acc_prev;
      logic        [SIDE_W-1:0]           side_prev;
      logic signed [atpr_pkg::COMP_W-1:0] x_in;
      logic signed [atpr_pkg::COMP_W-1:0] y_in;
      logic signed [atpr_pkg::ACC_W-1:0]  acc_in;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign x_prev    = in_x;
         assign y_prev    = in_y;
         assign acc_prev  = in_acc;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign acc_prev  = acc_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      // Rotate towards the x axis; a zero y counts as positive.
      always_comb begin
         if (y_prev[atpr_pkg::COMP_W-1]) begin
            x_in   = x_prev - (y_prev >>> i);
            y_in   = y_prev + (x_prev >>> i);
            acc_in = acc_prev - atpr_pkg::atan_entry(i);
         end else begin
            x_in   = x_prev + (y_prev >>> i);
            y_in   = y_prev - (x_prev >>> i);
            acc_in = acc_prev + atpr_pkg::atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            acc_ff[i]  <= acc_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_x     = x_ff[STEPS-1];
   assign out_acc   = acc_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

>>> rtl/core/accel_tilt_pitch_roll.sv
// ----------------------------------------------------------------------------
// Accelerometer tilt angles
// Pitch and roll in fixed-point degrees from one three-axis sample beat.
// ----------------------------------------------------------------------------
// Registers from sample beat to result beat: input stage, pass one, gain
// stage, rounding stage, pass two, finish stage and output register.
// Throughput: one beat per cycle while the output skid entry is empty; each
// CORDIC micro-rotation and each arithmetic step has its own register stage.
// Reset clears every valid bit and the output skid; no data is flushed.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_pitch_roll #(
   parameter int CORDIC_STEPS    = 16,
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  wire logic  clock,
   input  wire logic  reset,
   atpr_req_if.sink   req_ch,
   atpr_rsp_if.source rsp_ch
);

   localparam int COMP_W  = atpr_pkg::COMP_W;
   localparam int ACC_W   = atpr_pkg::ACC_W;
   localparam int ACCEL_W = atpr_pkg::ACCEL_W;
   localparam int PITCH_W = atpr_pkg::PITCH_W;
   localparam int ROLL_W  = atpr_pkg::ROLL_W;
   localparam int GUARD   = atpr_pkg::GUARD_BITS;
   // The x component stays positive through pass one, so its sign bit is dropped
   // before the gain multiplication.
   localparam int PROD_W  = (COMP_W - 1) + atpr_pkg::INV_GAIN_W;
   localparam int SIDE1_W = ACCEL_W + 2;
   localparam int SIDE2_W = ROLL_W + 1;

   // The whole pipeline moves together. It only halts when the output skid
   // register is holding a beat, which is a registered condition, so there is
   // no combinational path from rsp_ch.ready back to req_ch.ready.
   logic en;
   logic skid_valid_ff;

   assign en           = ~skid_valid_ff;
   assign req_ch.ready = en;

   // ------------------------------------------------------------------------
   // Input stage. A sample with negative z is mirrored through the origin so
   // that pass one starts in the right half plane; the accumulator is then
   // preloaded with plus or minus 180 degrees according to the sign of y.
   // ------------------------------------------------------------------------
   logic                      a_valid_ff;
   logic signed [COMP_W-1:0]  a_x_ff, a_x_in;
   logic signed [COMP_W-1:0]  a_y_ff, a_y_in;
   logic signed [ACC_W-1:0]   a_acc_ff, a_acc_in;
   logic        [SIDE1_W-1:0] a_side_ff, a_side_in;

   always_comb begin
      logic signed [COMP_W-1:0] vz;
      logic signed [COMP_W-1:0] vy;
      logic                     az_neg;
      logic                     ay_zero;
      vz      = $signed({{(COMP_W-ACCEL_W-GUARD){req_ch.accel_z[ACCEL_W-1]}},
                          req_ch.accel_z, {GUARD{1'b0}}});
      vy      = $signed({{(COMP_W-ACCEL_W-GUARD){req_ch.accel_y[ACCEL_W-1]}},
                          req_ch.accel_y, {GUARD{1'b0}}});
      az_neg  = req_ch.accel_z[ACCEL_W-1];
      ay_zero = (req_ch.accel_y == '0);
      if (az_neg) begin
         a_x_in   = -vz;
         a_y_in   = -vy;
         a_acc_in = req_ch.accel_y[ACCEL_W-1] ? -atpr_pkg::HALF_TURN
                                              : atpr_pkg::HALF_TURN;
      end else begin
         a_x_in   = vz;
         a_y_in   = vy;
         a_acc_in = '0;
      end
      a_side_in = {req_ch.accel_x, ay_zero, az_neg};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff    <= a_x_in;
         a_y_ff    <= a_y_in;
         a_acc_ff  <= a_acc_in;
         a_side_ff <= a_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pass one: vectors (z, y), giving roll and the scaled y-z magnitude.
   // ------------------------------------------------------------------------
   logic                      p1_valid;
   logic signed [COMP_W-1:0]  p1_x;
   logic signed [ACC_W-1:0]   p1_acc;
   logic        [SIDE1_W-1:0] p1_side;

   atpr_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (SIDE1_W)
   ) u_pass_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_x      (a_x_ff),
      .in_y      (a_y_ff),
      .in_acc    (a_acc_ff),
      .in_side   (a_side_ff),
      .out_valid (p1_valid),
      .out_x     (p1_x),
      .out_acc   (p1_acc),
      .out_side  (p1_side)
   );

   // ------------------------------------------------------------------------
   // Gain stage. The magnitude is multiplied by the inverse CORDIC gain. A
   // sample with zero y has its roll forced here: 180 degrees when z is
   // negative, otherwise 0, which also covers the all-zero case.
   // ------------------------------------------------------------------------
   logic                     m_valid_ff;
   logic        [PROD_W-1:0] m_prod_ff, m_prod_in;
   logic signed [ACC_W-1:0]  m_roll_ff, m_roll_in;
   logic [ACCEL_W-1:0]       m_ax_ff;

   assign m_prod_in = {{atpr_pkg::INV_GAIN_W{1'b0}}, p1_x[COMP_W-2:0]}
                    * {{(COMP_W-1){1'b0}}, atpr_pkg::INV_GAIN};

   always_comb begin
      if (p1_side[1]) begin
         m_roll_in = p1_side[0] ? atpr_pkg::HALF_TURN : '0;
      end else begin
         m_roll_in = p1_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= p1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff <= m_prod_in;
         m_roll_ff <= m_roll_in;
         m_ax_ff   <= p1_side[SIDE1_W-1:2];
      end
   end

   // ------------------------------------------------------------------------
   // Rounding stage. The product is rounded half up into the x input of pass
   // two, x is widened with its guard bits into the y input, and roll is
   // rounded, clamped and narrowed to its field now so that only the short
   // form travels down pass two.
   // ------------------------------------------------------------------------
   logic                      r_valid_ff;
   logic signed [COMP_W-1:0]  r_x_ff, r_x_in;
   logic signed [COMP_W-1:0]  r_y_ff, r_y_in;
   logic        [SIDE2_W-1:0] r_side_ff, r_side_in;
   logic        [PROD_W-1:0]  r_rounded;
   logic signed [ACC_W-1:0]   r_roll_full;

   assign r_rounded   = m_prod_ff + (PROD_W'(1) << (atpr_pkg::GAIN_SHIFT - 1));
   assign r_x_in      = $signed(COMP_W'(r_rounded >> atpr_pkg::GAIN_SHIFT));
   assign r_y_in      = $signed({{(COMP_W-ACCEL_W-GUARD){m_ax_ff[ACCEL_W-1]}},
                                 m_ax_ff, {GUARD{1'b0}}});
   assign r_roll_full = atpr_pkg::finish_angle(m_roll_ff, ANGLE_FRAC_BITS,
                                               atpr_pkg::ROLL_LIMIT_DEG, ROLL_W);
   assign r_side_in   = {r_roll_full[ROLL_W-1:0], (m_ax_ff == '0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (en) begin
         r_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_x_ff    <= r_x_in;
         r_y_ff    <= r_y_in;
         r_side_ff <= r_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Pass two: vectors (magnitude, x), giving pitch.
   // ------------------------------------------------------------------------
   logic                      p2_valid;
   logic signed [ACC_W-1:0]   p2_acc;
   logic        [SIDE2_W-1:0] p2_side;

   atpr_cordic #(
      .STEPS  (CORDIC_STEPS),
      .SIDE_W (SIDE2_W)
   ) u_pass_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (r_valid_ff),
      .in_x      (r_x_ff),
      .in_y      (r_y_ff),
      .in_acc    ('0),
      .in_side   (r_side_ff),
      .out_valid (p2_valid),
      .out_x     (),
      .out_acc   (p2_acc),
      .out_side  (p2_side)
   );

   // ------------------------------------------------------------------------
   // Finish stage. Pitch is exactly zero when x is zero; otherwise it is
   // rounded, clamped to 90 degrees and narrowed to its field.
   // ------------------------------------------------------------------------
   logic                       f_valid_ff;
   logic signed [PITCH_W-1:0]  f_pitch_ff;
   logic signed [ROLL_W-1:0]   f_roll_ff;
   logic signed [ACC_W-1:0]    f_pitch_acc;
   logic signed [ACC_W-1:0]    f_pitch_full;

   assign f_pitch_acc  = p2_side[0] ? '0 : p2_acc;
   assign f_pitch_full = atpr_pkg::finish_angle(f_pitch_acc, ANGLE_FRAC_BITS,
                                                atpr_pkg::PITCH_LIMIT_DEG, PITCH_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= p2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_pitch_ff <= f_pitch_full[PITCH_W-1:0];
         f_roll_ff  <= $signed(p2_side[SIDE2_W-1:1]);
      end
   end

   // ------------------------------------------------------------------------
   // Output register with a skid entry. When the sink stalls, the beat that
   // leaves the finish stage in that cycle is parked in the skid entry and
   // the pipeline halts until the skid entry has drained.
   // ------------------------------------------------------------------------
   logic                      out_valid_ff;
   logic signed [PITCH_W-1:0] out_pitch_ff;
   logic signed [ROLL_W-1:0]  out_roll_ff;
   logic signed [PITCH_W-1:0] skid_pitch_ff;
   logic signed [ROLL_W-1:0]  skid_roll_ff;
   logic                      out_free;

   assign out_free = ~out_valid_ff | rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= f_valid_ff;
         end
      end else if (en && f_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_pitch_ff <= skid_pitch_ff;
            out_roll_ff  <= skid_roll_ff;
         end else begin
            out_pitch_ff <= f_pitch_ff;
            out_roll_ff  <= f_roll_ff;
         end
      end else if (en && f_valid_ff) begin
         skid_pitch_ff <= f_pitch_ff;
         skid_roll_ff  <= f_roll_ff;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.pitch_angle = out_pitch_ff;
   assign rsp_ch.roll_angle  = out_roll_ff;

endmodule

`default_nettype wire
